/* src/mpni_pkg.sv */
// ----------------------------------------------------------------------------
// mpni_pkg
// Shared request codes, constants and the controller/datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package mpni_pkg;
  localparam logic [2:0] REQ_WR_IN_W   = 3'd0;
  localparam logic [2:0] REQ_WR_OUT_W  = 3'd1;
  localparam logic [2:0] REQ_WR_IN_B   = 3'd2;
  localparam logic [2:0] REQ_WR_OUT_B  = 3'd3;
  localparam logic [2:0] REQ_START     = 3'd4;
  localparam logic [2:0] REQ_PIECE     = 3'd5;
  localparam logic [2:0] REQ_THREAT    = 3'd6;
  localparam logic [2:0] REQ_SCORE     = 3'd7;

  localparam int THREAT_BASE = 768;
  localparam logic [5:0] MIRROR_XOR = 6'd56;
  localparam int FEATURE_ROWS = 832;

  // per-cycle command from controller to datapath
  typedef struct packed {
    logic       wr_in_w;
    logic       wr_out_w;
    logic       wr_in_b;
    logic       wr_out_b;
    logic       rd_in_w;    // issue input-weight read for current row/unit
    logic       rd_bias;    // issue input-bias read for current unit
    logic       rd_out;     // issue output-weight read
    logic       acc_add;    // add pending weight into accumulator
    logic       acc_load;   // load pending bias into accumulator
    logic       mac;        // accumulate product into logit
    logic       clr_sum;
    logic       fin;        // present result: raises move_strobe
  } dp_cmd_t;
endpackage
`default_nettype wire

/* src/mpni_ctrl.sv */
// ----------------------------------------------------------------------------
// mpni_ctrl
// Sequencer: scans set board bits and sweeps hidden units one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mpni_ctrl #(
  parameter int HIDDEN_UNITS = 32,
  parameter int UW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [2:0]   req_type,
  input  wire logic         side_to_move,
  input  wire logic [3:0]   piece_index,
  input  wire logic [63:0]  board_bits,
  output logic              busy,
  output mpni_pkg::dp_cmd_t cmd,
  output logic [9:0]        row,
  output logic [UW-1:0]     unit,
  output logic [UW-1:0]     unit_d
);
  import mpni_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_BIAS = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [UW-1:0] LAST = UW'(HIDDEN_UNITS - 1);

  logic [2:0]  state;
  logic [63:0] bits;
  logic [5:0]  sq;
  logic [9:0]  base;
  logic        white;
  logic        pend_add, pend_bias, pend_mac;
  logic        score_run;
  logic [3:0]  pk;

  // piece kind is formed from the live side bit at the accepting edge
  always_comb begin
    pk = side_to_move ? piece_index : ((piece_index < 4'd6) ? piece_index + 4'd6
                                                             : piece_index - 4'd6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend_add <= 1'b0;
      pend_bias <= 1'b0;
      pend_mac <= 1'b0;
      score_run <= 1'b0;
    end else begin
      pend_add <= cmd.rd_in_w;
      pend_bias <= cmd.rd_bias;
      pend_mac <= cmd.rd_out;
      score_run <= pend_mac;
      unit_d <= unit;
      case (state)
        S_IDLE: begin
          unit <= '0;
          sq <= '0;
          white <= side_to_move;
          bits <= board_bits;
          if (start) begin
            case (req_type)
              REQ_START: state <= S_BIAS;
              REQ_PIECE: begin
                base <= {pk[3:0], 6'd0};
                if (side_to_move ? (piece_index <= 4'd11) : (piece_index <= 4'd11))
                  state <= S_SCAN;
              end
              REQ_THREAT: begin
                base <= 10'(THREAT_BASE);
                state <= S_SCAN;
              end
              REQ_SCORE: state <= S_OUT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (sq == 6'd63 && !bits[sq]) state <= S_FIN;
          else if (bits[sq]) begin
            row <= base + 10'(white ? sq : (sq ^ MIRROR_XOR));
            unit <= '0;
            state <= S_ROW;
          end else sq <= sq + 6'd1;
        end
        S_ROW: begin
          unit <= unit + 1'b1;
          if (unit == LAST) begin
            bits[sq] <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_BIAS, S_OUT: begin
          unit <= unit + 1'b1;
          if (unit == LAST) state <= S_FIN;
        end
        S_FIN: if (!pend_add && !pend_bias && !pend_mac) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    if (state == S_IDLE && start) begin
      cmd.wr_in_w  = (req_type == REQ_WR_IN_W);
      cmd.wr_out_w = (req_type == REQ_WR_OUT_W);
      cmd.wr_in_b  = (req_type == REQ_WR_IN_B);
      cmd.wr_out_b = (req_type == REQ_WR_OUT_B);
      cmd.clr_sum  = (req_type == REQ_SCORE);
    end
    cmd.rd_in_w  = (state == S_ROW);
    cmd.rd_bias  = (state == S_BIAS);
    cmd.rd_out   = (state == S_OUT);
    cmd.acc_add  = pend_add;
    cmd.acc_load = pend_bias;
    cmd.mac      = pend_mac;
    // first cycle after the last mac has retired
    cmd.fin      = score_run && !pend_mac;
  end
endmodule
`default_nettype wire

/* src/mpni_dp.sv */
// ----------------------------------------------------------------------------
// mpni_dp
// Weight memories, hidden accumulator and the output multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none
module mpni_dp #(
  parameter int HIDDEN_UNITS = 32,
  parameter int UW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mpni_pkg::dp_cmd_t  cmd,
  input  wire logic [9:0]         row,
  input  wire logic [UW-1:0]      unit,
  input  wire logic [UW-1:0]      unit_d,
  input  wire logic [16:0]        weight_index,
  input  wire logic signed [15:0] weight_value,
  input  wire logic               side_to_move,
  input  wire logic [5:0]         move_from,
  input  wire logic [5:0]         move_to,
  output logic                    move_strobe,
  output logic signed [31:0]      move_logit
);
  import mpni_pkg::*;

  localparam int IN_W = FEATURE_ROWS * HIDDEN_UNITS;
  localparam int OUT_W = HIDDEN_UNITS * 4096;
  localparam int IAW = $clog2(IN_W);
  localparam int OAW = $clog2(OUT_W);

  logic [15:0] in_w   [IN_W];
  logic [15:0] out_w  [OUT_W];
  logic [15:0] in_b   [HIDDEN_UNITS];
  logic [15:0] out_b  [4096];
  logic [15:0] acc    [HIDDEN_UNITS];
  logic [15:0] rd_w, rd_b, rd_ow, rd_ob;
  logic [11:0] idx;
  logic [31:0] sum;

  always_ff @(posedge clk) begin
    if (cmd.wr_in_w && 32'(weight_index) < IN_W) in_w[weight_index[IAW-1:0]] <= weight_value;
    if (cmd.rd_in_w) rd_w <= in_w[IAW'(row) * IAW'(HIDDEN_UNITS) + IAW'(unit)];
  end
  always_ff @(posedge clk) begin
    if (cmd.wr_out_w && 32'(weight_index) < OUT_W)
      out_w[weight_index[OAW-1:0]] <= weight_value;
    if (cmd.rd_out) rd_ow <= out_w[{unit, idx}];
  end
  always_ff @(posedge clk) begin
    if (cmd.wr_in_b && 32'(weight_index) < HIDDEN_UNITS) in_b[weight_index[UW-1:0]] <= weight_value;
    if (cmd.rd_bias) rd_b <= in_b[unit];
  end
  always_ff @(posedge clk) begin
    if (cmd.wr_out_b && weight_index < 17'd4096) out_b[weight_index[11:0]] <= weight_value;
    rd_ob <= out_b[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sum)
      idx <= side_to_move ? {move_from, move_to}
                          : {move_from ^ MIRROR_XOR, move_to ^ MIRROR_XOR};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIDDEN_UNITS; i++) acc[i] <= '0;
    end else if (cmd.acc_add) acc[unit_d] <= acc[unit_d] + rd_w;
    else if (cmd.acc_load) acc[unit_d] <= rd_b;
  end

  logic signed [15:0] a;
  logic signed [31:0] prod;
  always_comb begin
    a = acc[unit_d];
    prod = a * $signed(rd_ow);
  end

  always_ff @(posedge clk) begin
    if (rst) move_strobe <= 1'b0;
    else move_strobe <= cmd.fin;
    if (cmd.clr_sum) sum <= '0;
    else if (cmd.mac && a > 0) sum <= sum + prod;
    move_logit <= sum + 32'($signed(rd_ob));
  end
endmodule
`default_nettype wire

/* src/move_policy_net_inference.sv */
// ----------------------------------------------------------------------------
// move_policy_net_inference
// Integer part of a two-layer chess move-policy net.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy low. A write leaves
// busy low; start holds busy while it loads each input bias into the
// accumulator; a piece or threat item holds busy while it scans the board
// one square or one hidden unit per cycle, adding one input-weight row into
// the accumulator for each set bit; a score item holds busy while it sweeps
// the hidden units through one multiply-accumulate and raises move_strobe
// with move_logit for one cycle, when busy is already low again.
// The receiver cannot stall.
`default_nettype none
module move_policy_net_inference #(
  parameter int HIDDEN_UNITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         req_type,
  input  wire logic [16:0]        weight_index,
  input  wire logic signed [15:0] weight_value,
  input  wire logic               side_to_move,
  input  wire logic [3:0]         piece_index,
  input  wire logic [63:0]        board_bits,
  input  wire logic [5:0]         move_from,
  input  wire logic [5:0]         move_to,
  output logic                    move_strobe,
  output logic signed [31:0]      move_logit
);
  import mpni_pkg::*;
  localparam int UW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

  dp_cmd_t cmd;
  logic [9:0] row;
  logic [UW-1:0] unit, unit_d;

  mpni_ctrl #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_ctrl (
    .clk, .rst, .start, .req_type, .side_to_move, .piece_index, .board_bits,
    .busy, .cmd, .row, .unit, .unit_d
  );

  mpni_dp #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_dp (
    .clk, .rst, .cmd, .row, .unit, .unit_d, .weight_index, .weight_value,
    .side_to_move, .move_from, .move_to, .move_strobe, .move_logit
  );

`ifndef ASSERT_OFF
  a_no_strobe_rst: assert property (@(posedge clk) rst |=> !move_strobe)
    else $error("strobe after reset");
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> busy) else $error("result while idle");
`endif
endmodule
`default_nettype wire
